FILE: rtl/ivm_pkg.sv
`timescale 1ns / 1ps
package ivm_pkg;

	// Item modes
	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_MARK  = 2'd1;
	localparam logic [1:0] MODE_ALLOC = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// Stream word widths
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_UPDATE
	} state_t;

	// Update applied by every cell of the row in the same cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,     // slot at search position takes id
		OP_INC,     // slot at search position takes id + 1
		OP_INSERT,  // open two slots at search position: id, id + 1
		OP_MERGE    // close two slots at search position
	} op_t;

	typedef struct packed {
		logic capture;  // latch compare flags
		op_t  op;
	} cell_ctl_t;

endpackage

FILE: rtl/interval_id_map.sv
`timescale 1ns / 1ps
// Each accepted word takes a compare cycle across the cell row (ST_DECIDE) and
// a shift/overwrite cycle of the row (ST_UPDATE), which also loads the result
// word into the output register; the next word is taken in the shift cycle
// when the output register is free or being emptied, else the row waits.
// Reset (asynchronous): list holds id 1 as used, two valid slots, no words held.
module interval_id_map #(
	parameter int MAX_BOUNDARIES = 64,
	parameter int ID_BITS        = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ivm_pkg::IN_DATA_W-1:0]      s_tdata,   // mode[1:0], id[33:2]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ivm_pkg::OUT_DATA_W-1:0]     m_tdata    // was_used[0], result_id[32:1], status[34:33]
);
	import ivm_pkg::*;

	localparam int N  = MAX_BOUNDARIES;
	localparam int CW = $clog2(MAX_BOUNDARIES + 1);

	state_t state_q, state_d;

	logic [1:0]         mode_q;
	logic [ID_BITS-1:0] id_q;
	logic [ID_BITS-1:0] id_s1, idp1_s1;
	logic [ID_BITS-1:0] cmp_id, cmp_idp1;
	logic [CW-1:0]      cnt_q;
	logic [63:0]        id_ext, rid_ext;

	logic [ID_BITS-1:0] b_vec [N];
	logic [N-1:0]       ge_c, at_pos_s1, eq_s1, eqp_s1;

	logic      accept, go_upd;
	cell_ctl_t ctl;

	logic hit, pos_odd, hitp_pos, hitp_next, used, mark, full, top;
	op_t        op_dec;
	logic [1:0] stat_dec;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign accept = s_tvalid && s_tready;
	assign go_upd = !out_valid_q || m_tready;
	assign id_ext = 64'(s_tdata[33:2]);

	// Input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tdata[1:0];
			id_q   <= id_ext[ID_BITS-1:0];
		end
	end

	// Searched id: allocation takes the first free id after the first run
	assign cmp_id   = (mode_q == MODE_ALLOC) ? b_vec[1] : id_q;
	assign cmp_idp1 = cmp_id + ID_BITS'(1);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			id_s1   <= cmp_id;
			idp1_s1 <= cmp_idp1;
		end
	end

	// Cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic               ge_l, atp_l, vld;
		logic [ID_BITS-1:0] bl2, br2;

		assign vld = cnt_q > CW'(i);
		if (i == 0) begin : g_l0
			assign ge_l  = 1'b0;
			assign atp_l = 1'b0;
		end else begin : g_ln
			assign ge_l  = ge_c[i-1];
			assign atp_l = at_pos_s1[i-1];
		end
		if (i < 2) begin : g_b0
			assign bl2 = '0;
		end else begin : g_bn
			assign bl2 = b_vec[i-2];
		end
		if (i + 2 < N) begin : g_r
			assign br2 = b_vec[i+2];
		end else begin : g_r0
			assign br2 = '0;
		end

		ivm_cell #(
			.ID_BITS (ID_BITS),
			.IDX     (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.valid          (vld),
			.cmp_id         (cmp_id),
			.cmp_idp1       (cmp_idp1),
			.upd_id         (id_s1),
			.upd_idp1       (idp1_s1),
			.ge_left        (ge_l),
			.at_pos_left_s1 (atp_l),
			.b_left2        (bl2),
			.b_right2       (br2),
			.b              (b_vec[i]),
			.ge             (ge_c[i]),
			.at_pos_s1      (at_pos_s1[i]),
			.eq_s1          (eq_s1[i]),
			.eqp_s1         (eqp_s1[i])
		);
	end

	// Row reductions
	always_comb begin
		hit       = |(at_pos_s1 & eq_s1);
		hitp_pos  = |(at_pos_s1 & eqp_s1);
		pos_odd   = 1'b0;
		hitp_next = 1'b0;
		for (int i = 1; i < N; i++) begin
			if (i % 2 == 1) pos_odd = pos_odd | at_pos_s1[i];
			hitp_next = hitp_next | (at_pos_s1[i-1] & eqp_s1[i]);
		end
	end

	// Decision
	assign used = hit ^ pos_odd;
	assign mark = (mode_q == MODE_MARK) || (mode_q == MODE_ALLOC);
	assign full = cnt_q > CW'(MAX_BOUNDARIES - 2);
	assign top  = &id_s1;

	always_comb begin
		op_dec   = OP_NONE;
		stat_dec = STAT_OK;
		if (mark && !used) begin
			priority if (top) begin
				stat_dec = STAT_RANGE;
			end else if (!pos_odd) begin
				priority if (hitp_pos) op_dec = OP_SET;
				else if (full) stat_dec = STAT_FULL;
				else op_dec = OP_INSERT;
			end else begin
				op_dec = hitp_next ? OP_MERGE : OP_INC;
			end
		end
	end

	// Slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(2);
		end else if (ctl.op == OP_INSERT) begin
			cnt_q <= cnt_q + CW'(2);
		end else if (ctl.op == OP_MERGE) begin
			cnt_q <= cnt_q - CW'(2);
		end
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_UPDATE;
			ST_UPDATE: if (go_upd) state_d = accept ? ST_DECIDE : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		s_tready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.op      = OP_NONE;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_DECIDE: ctl.capture = 1'b1;
			ST_UPDATE: begin
				s_tready = go_upd;
				if (go_upd) ctl.op = op_dec;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Output register
	assign rid_ext = 64'(id_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_UPDATE && go_upd) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && go_upd) begin
			out_data_q <= {5'd0, stat_dec, rid_ext[31:0], used};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	a_cnt_even: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] == 1'b0) else $error("slot count odd");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(2)) && (cnt_q <= CW'(MAX_BOUNDARIES)))
		else $error("slot count out of range");
	a_one_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $onehot0(at_pos_s1))
		else $error("several search positions");
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DECIDE) else $error("accepted word not decided");
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_UPDATE))
		else $error("result without update");

endmodule

FILE: rtl/ivm_cell.sv
`timescale 1ns / 1ps
module ivm_cell #(
	parameter int ID_BITS = 32,
	parameter int IDX     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ivm_pkg::cell_ctl_t   ctl,
	input  logic                 valid,
	input  logic [ID_BITS-1:0]   cmp_id,
	input  logic [ID_BITS-1:0]   cmp_idp1,
	input  logic [ID_BITS-1:0]   upd_id,
	input  logic [ID_BITS-1:0]   upd_idp1,
	input  logic                 ge_left,
	input  logic                 at_pos_left_s1,
	input  logic [ID_BITS-1:0]   b_left2,
	input  logic [ID_BITS-1:0]   b_right2,
	output logic [ID_BITS-1:0]   b,
	output logic                 ge,
	output logic                 at_pos_s1,
	output logic                 eq_s1,
	output logic                 eqp_s1
);
	import ivm_pkg::*;

	localparam logic [ID_BITS-1:0] RST_VAL = (IDX == 0) ? ID_BITS'(1) :
		(IDX == 1) ? ID_BITS'(2) : '0;

	logic [ID_BITS-1:0] b_q;
	logic               eq_c;
	logic               eqp_c;
	logic               ge_s1;

	// Compare against the searched id
	assign ge    = !(valid && (b_q < cmp_id));
	assign eq_c  = valid && (b_q == cmp_id);
	assign eqp_c = valid && (b_q == cmp_idp1);
	assign b     = b_q;

	// Flags for the update cycle
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			ge_s1     <= ge;
			at_pos_s1 <= ge && !ge_left;
			eq_s1     <= eq_c;
			eqp_s1    <= eqp_c;
		end
	end

	// Boundary value: shift or overwrite
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= RST_VAL;
		end else begin
			unique case (ctl.op)
				OP_SET: begin
					if (at_pos_s1) b_q <= upd_id;
				end
				OP_INC: begin
					if (at_pos_s1) b_q <= upd_idp1;
				end
				OP_INSERT: begin
					if (at_pos_s1) b_q <= upd_id;
					else if (at_pos_left_s1) b_q <= upd_idp1;
					else if (ge_s1) b_q <= b_left2;
				end
				OP_MERGE: begin
					if (ge_s1) b_q <= b_right2;
				end
				default: begin
					b_q <= b_q;
				end
			endcase
		end
	end

endmodule
